// ----- hdl/tlcd_pkg.sv -----
// shared types, widths and codes for the track line crossing detector
// no dependencies; imported by tlcd_side_calc and the top level
`default_nettype none

package tlcd_pkg;

  // field widths
  localparam int COORD_W       = 16;
  localparam int DIFF_W        = COORD_W + 1;
  localparam int PROD_W        = 2 * DIFF_W;
  localparam int SIDE_W        = 35;
  localparam int OUT_SIDE_W    = 36;
  localparam int DB_W          = 35;
  localparam int TIME_W        = 63;
  localparam int IN_SLOT_W     = 6;
  localparam int IN_SLOT_COUNT = 1 << IN_SLOT_W;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 35;
  localparam int IN_DATA_W     = 104;
  localparam int OUT_DATA_W    = 144;

  // defaults
  localparam int TRACK_SLOTS_DEF = 64;
  localparam logic [DB_W-1:0] DEADBAND_RESET = 35'd2147484;
  localparam logic [COORD_W-1:0] COORD_MAX = '1;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LINE_START_X = 3'd0,
    REG_LINE_START_Y = 3'd1,
    REG_LINE_END_X   = 3'd2,
    REG_LINE_END_Y   = 3'd3,
    REG_ALLOWED_DIR  = 3'd4,
    REG_SIDE_DEADBAND = 3'd5
  } cfg_reg_t;

  // crossing direction codes
  typedef enum logic [1:0] {
    DIR_NONE    = 2'd0,
    DIR_FORWARD = 2'd1,
    DIR_REVERSE = 2'd2
  } dir_t;

  // direction filter value that lets every direction count
  localparam logic [1:0] ALLOW_ANY = 2'd0;

  // request kinds
  localparam logic REQ_OBSERVE   = 1'b0;
  localparam logic REQ_TERMINATE = 1'b1;

  // table sequencer states
  typedef enum logic {
    ST_CLEAR,
    ST_RUN
  } tlcd_state_t;

  // configured line
  typedef struct packed {
    logic [COORD_W-1:0] start_x;
    logic [COORD_W-1:0] start_y;
    logic [COORD_W-1:0] end_x;
    logic [COORD_W-1:0] end_y;
  } line_t;

  // one entry of the per-track table
  typedef struct packed {
    logic                     valid;
    logic signed [SIDE_W-1:0] side;
    logic [TIME_W-1:0]        cross_time;
  } track_ent_t;

endpackage

`default_nettype wire

// ----- hdl/track_line_crossing_detector_unit.sv -----
// Track line crossing detector. Each observation beat (tuser 0) computes the signed side of
// its point against the configured line and checks it against the track's stored side;
// a terminate beat (tuser 1) clears the track's entry and gives no result. One beat is
// accepted per cycle unless the output register holds an untaken beat or the table is
// clearing; a result goes through stage 1, stage 2 and the output register. The per-track
// table is a single-port-write, registered-read memory; a back-to-back update of the same
// slot is served by forwarding from the write stage and from the last write. After reset
// the table is cleared, one entry a cycle, with in_tready held low. The user must ensure
// configuration is written only while the block is idle; the block does not enforce it.
// depends on tlcd_pkg and tlcd_side_calc
`default_nettype none

module track_line_crossing_detector_unit import tlcd_pkg::*; #(
  parameter int TRACK_SLOTS = TRACK_SLOTS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // input beats
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // track_slot[5:0], point_x[21:6], point_y[37:22], obs_time[100:38], zero pad
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  // req_type[0]
  input  wire logic                  in_tuser,
  // result beats
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // side_now[35:0], side_prior[71:36], crossed[72], cross_direction[74:73],
  // last_cross_ns[137:75], zero pad
  output logic [OUT_DATA_W-1:0]      out_tdata,
  // configuration writes
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int SLOT_W = (TRACK_SLOTS > 1) ? $clog2(TRACK_SLOTS) : 1;
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(TRACK_SLOTS - 1);

  // configuration registers
  line_t             line_r;
  logic [1:0]        allow_dir_r;
  logic [DB_W-1:0]   deadband_r;

  // table sequencer
  tlcd_state_t       state_r;
  tlcd_state_t       state_nxt;
  logic [SLOT_W-1:0] clr_addr_r;
  logic              clearing;

  // input unpack
  logic [IN_SLOT_W-1:0] in_track_slot;
  logic [COORD_W-1:0]   in_point_x;
  logic [COORD_W-1:0]   in_point_y;
  logic [TIME_W-1:0]    in_ts;
  logic [SLOT_W-1:0]    in_slot;
  logic                 in_fire;
  logic                 adv;

  // stage 1: table read in flight, operands held for the multipliers
  logic                 s1_v_r;
  logic                 s1_req_r;
  logic [SLOT_W-1:0]    s1_slot_r;
  logic [COORD_W-1:0]   s1_x_r;
  logic [COORD_W-1:0]   s1_y_r;
  logic [TIME_W-1:0]    s1_ts_r;

  // stage 2: products ready, entry forwarded, decide and write back
  logic                 s2_v_r;
  logic                 s2_req_r;
  logic [SLOT_W-1:0]    s2_slot_r;
  logic [TIME_W-1:0]    s2_ts_r;
  track_ent_t           s2_ent_r;
  logic signed [PROD_W-1:0] prod_a_r;
  logic signed [PROD_W-1:0] prod_b_r;

  // table memory and forwarding
  track_ent_t           mem [TRACK_SLOTS];
  track_ent_t           rd_ent_r;
  track_ent_t           fwd_ent;
  logic                 mem_we;
  logic [SLOT_W-1:0]    mem_waddr;
  track_ent_t           mem_wdata;
  logic                 wb_v_r;
  logic [SLOT_W-1:0]    wb_slot_r;
  track_ent_t           wb_ent_r;

  // stage 2 decision
  logic signed [SIDE_W-1:0] cur_side;
  logic signed [SIDE_W-1:0] prev_side;
  logic [SIDE_W-1:0]        cur_mag;
  logic [SIDE_W-1:0]        prev_mag;
  logic                     cur_out;
  logic                     prev_out;
  logic                     had;
  dir_t                     dir;
  logic                     dir_ok;
  logic                     crossed;
  track_ent_t               wr_ent;

  // output register
  logic                         out_v_r;
  logic signed [OUT_SIDE_W-1:0] out_cur_r;
  logic signed [OUT_SIDE_W-1:0] out_prev_r;
  logic                         out_crossed_r;
  dir_t                         out_dir_r;
  logic [TIME_W-1:0]            out_last_r;

  // configuration port, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_r.start_x <= '0;
      line_r.start_y <= '0;
      line_r.end_x   <= COORD_MAX;
      line_r.end_y   <= COORD_MAX;
      allow_dir_r    <= ALLOW_ANY;
      deadband_r     <= DEADBAND_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_LINE_START_X:  line_r.start_x <= cfg_data[COORD_W-1:0];
        REG_LINE_START_Y:  line_r.start_y <= cfg_data[COORD_W-1:0];
        REG_LINE_END_X:    line_r.end_x   <= cfg_data[COORD_W-1:0];
        REG_LINE_END_Y:    line_r.end_y   <= cfg_data[COORD_W-1:0];
        REG_ALLOWED_DIR:   allow_dir_r    <= cfg_data[1:0];
        REG_SIDE_DEADBAND: deadband_r     <= cfg_data[DB_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer: clearing pass after reset, then run
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: if (clr_addr_r == SLOT_LAST) state_nxt = ST_RUN;
      ST_RUN:   state_nxt = ST_RUN;
      default:  state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    clearing = (state_r == ST_CLEAR);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      clr_addr_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (clearing) clr_addr_r <= clr_addr_r + SLOT_W'(1);
    end
  end

  // input unpack and slot folding (constant table over the 64 slot codes)
  assign in_track_slot = in_tdata[5:0];
  assign in_point_x    = in_tdata[21:6];
  assign in_point_y    = in_tdata[37:22];
  assign in_ts         = in_tdata[100:38];

  always_comb begin
    in_slot = '0;
    for (int i = 0; i < IN_SLOT_COUNT; i++) begin
      if (in_track_slot == IN_SLOT_W'(i)) in_slot = SLOT_W'(i % TRACK_SLOTS);
    end
  end

  // whole pipe moves when the output register can take a beat
  assign adv       = !out_v_r || out_tready;
  assign in_tready = adv && !clearing;
  assign in_fire   = in_tvalid && in_tready;

  // stage 1
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= in_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_req_r  <= in_tuser;
      s1_slot_r <= in_slot;
      s1_x_r    <= in_point_x;
      s1_y_r    <= in_point_y;
      s1_ts_r   <= in_ts;
    end
  end

  // multipliers between stage 1 and stage 2
  tlcd_side_calc u_side_calc (
    .clk      (clk),
    .en       (adv),
    .line_cfg (line_r),
    .point_x  (s1_x_r),
    .point_y  (s1_y_r),
    .prod_a_r (prod_a_r),
    .prod_b_r (prod_b_r)
  );

  // table memory: registered read at accept, one write per cycle
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (in_fire) rd_ent_r <= mem[in_slot];
  end

  always_comb begin
    if (clearing) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr_r;
      mem_wdata = '0;
    end else begin
      mem_we    = adv && s2_v_r;
      mem_waddr = s2_slot_r;
      mem_wdata = wr_ent;
    end
  end

  // last write, for a read that raced it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wb_v_r <= 1'b0;
    end else if (clearing) begin
      wb_v_r <= 1'b0;
    end else if (mem_we) begin
      wb_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      wb_slot_r <= mem_waddr;
      wb_ent_r  <= mem_wdata;
    end
  end

  // forwarding into stage 2: newest write wins
  always_comb begin
    priority if (s2_v_r && (s2_slot_r == s1_slot_r)) fwd_ent = wr_ent;
    else if (wb_v_r && (wb_slot_r == s1_slot_r))     fwd_ent = wb_ent_r;
    else                                             fwd_ent = rd_ent_r;
  end

  // stage 2
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (adv) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_req_r  <= s1_req_r;
      s2_slot_r <= s1_slot_r;
      s2_ts_r   <= s1_ts_r;
      s2_ent_r  <= fwd_ent;
    end
  end

  // side, deadband and direction checks
  always_comb begin
    cur_side  = SIDE_W'(prod_a_r) - SIDE_W'(prod_b_r);
    had       = s2_ent_r.valid;
    prev_side = had ? s2_ent_r.side : cur_side;
    cur_mag   = cur_side[SIDE_W-1]  ? SIDE_W'(-cur_side)  : SIDE_W'(cur_side);
    prev_mag  = prev_side[SIDE_W-1] ? SIDE_W'(-prev_side) : SIDE_W'(prev_side);
    cur_out   = cur_mag > deadband_r;
    prev_out  = prev_mag > deadband_r;

    priority if (prev_side < 0 && cur_side > 0) dir = DIR_FORWARD;
    else if (prev_side > 0 && cur_side < 0)     dir = DIR_REVERSE;
    else                                        dir = DIR_NONE;

    dir_ok  = (allow_dir_r == ALLOW_ANY) || (allow_dir_r == 2'(dir));
    crossed = had && cur_out && prev_out && (dir != DIR_NONE) && dir_ok;

    if (s2_req_r == REQ_TERMINATE) begin
      wr_ent = '0;
    end else begin
      wr_ent.valid      = had || cur_out;
      wr_ent.side       = cur_out ? cur_side : s2_ent_r.side;
      wr_ent.cross_time = crossed ? s2_ts_r : s2_ent_r.cross_time;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= s2_v_r && (s2_req_r == REQ_OBSERVE);
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s2_v_r && (s2_req_r == REQ_OBSERVE)) begin
      out_cur_r     <= OUT_SIDE_W'(cur_side);
      out_prev_r    <= OUT_SIDE_W'(prev_side);
      out_crossed_r <= crossed;
      out_dir_r     <= crossed ? dir : DIR_NONE;
      out_last_r    <= wr_ent.cross_time;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {6'b0, out_last_r, out_dir_r, out_crossed_r, out_prev_r, out_cur_r};

  // checks
  a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> !in_tready)
    else $error("input accepted during table clear");

  a_cross_has_direction: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_crossed_r) |-> (out_dir_r == DIR_FORWARD || out_dir_r == DIR_REVERSE))
    else $error("crossing without direction");

  a_cross_sides_differ: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_crossed_r) |->
      (out_cur_r[OUT_SIDE_W-1] != out_prev_r[OUT_SIDE_W-1]))
    else $error("crossing with sides of equal sign");

  a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (int'(mem_waddr) < TRACK_SLOTS))
    else $error("table write beyond depth");

  a_result_from_observe: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_v_r) |-> $past(s2_v_r && (s2_req_r == REQ_OBSERVE)))
    else $error("result without an observation");

endmodule

`default_nettype wire

// ----- hdl/tlcd_side_calc.sv -----
// side-of-line products: (end - start) x (point - start), one product pair per beat
// depends on tlcd_pkg
`default_nettype none

module tlcd_side_calc import tlcd_pkg::*; (
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire line_t                    line_cfg,
  input  wire logic [COORD_W-1:0]       point_x,
  input  wire logic [COORD_W-1:0]       point_y,
  output logic signed [PROD_W-1:0]      prod_a_r,
  output logic signed [PROD_W-1:0]      prod_b_r
);

  logic signed [DIFF_W-1:0] line_dx;
  logic signed [DIFF_W-1:0] line_dy;
  logic signed [DIFF_W-1:0] pt_dx;
  logic signed [DIFF_W-1:0] pt_dy;

  // differences against the line start, one bit wider and signed
  always_comb begin
    line_dx = signed'({1'b0, line_cfg.end_x})   - signed'({1'b0, line_cfg.start_x});
    line_dy = signed'({1'b0, line_cfg.end_y})   - signed'({1'b0, line_cfg.start_y});
    pt_dx   = signed'({1'b0, point_x})          - signed'({1'b0, line_cfg.start_x});
    pt_dy   = signed'({1'b0, point_y})          - signed'({1'b0, line_cfg.start_y});
  end

  // two 17x17 signed multipliers, registered
  always_ff @(posedge clk) begin
    if (en) begin
      prod_a_r <= line_dx * pt_dy;
      prod_b_r <= line_dy * pt_dx;
    end
  end

endmodule

`default_nettype wire
